// ===== rtl/vgs_pkg.sv =====
package vgs_pkg;

    localparam int POS_W = 10;
    localparam int ORG_W = 18;
    localparam int DIR_W = 16;
    localparam int MAP_W = 12;
    localparam int NUM_W = 9;
    localparam int DEN_W = 16;
    localparam int P_W   = 35;
    localparam int STEP_W = 10;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 56;
    localparam int RESET_STEPS = 1000;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAY   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RAY   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic REG_MAX_STEPS = 1'b0;
    localparam logic REG_AIR_CODE  = 1'b1;

    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_CLR        = 4'd1;
    localparam logic [3:0] CMD_LOAD       = 4'd2;
    localparam logic [3:0] CMD_ADDR1      = 4'd3;
    localparam logic [3:0] CMD_ADDR2      = 4'd4;
    localparam logic [3:0] CMD_MEMRD      = 4'd5;
    localparam logic [3:0] CMD_EMIT_READ  = 4'd6;
    localparam logic [3:0] CMD_WCHK       = 4'd7;
    localparam logic [3:0] CMD_MASK       = 4'd8;
    localparam logic [3:0] CMD_EMIT_DIRTY = 4'd9;
    localparam logic [3:0] CMD_EMIT_CLEAR = 4'd10;
    localparam logic [3:0] CMD_MUL        = 4'd11;
    localparam logic [3:0] CMD_STEP       = 4'd12;
    localparam logic [3:0] CMD_EMIT_RAY   = 4'd13;
    localparam logic [3:0] CMD_EMIT_NOHIT = 4'd14;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic k_last;
        logic trivial;
        logic ray_hit;
        logic steps_done;
        logic emit_last;
    } stat_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [7:0]              new_type;
        logic [5:0]              chunk_sel;
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic signed [ORG_W-1:0] origin_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } in_t;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic [7:0]              type_out;
        logic                    dirty_valid;
        logic [5:0]              dirty_chunk;
        logic                    hit;
        logic signed [MAP_W-1:0] hit_x;
        logic signed [MAP_W-1:0] hit_y;
        logic signed [MAP_W-1:0] hit_z;
        logic [2:0]              hit_face;
        logic                    last;
    } res_t;

endpackage

// ===== rtl/vgs_ctrl.sv =====
module vgs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_opcode,
    input  vgs_pkg::stat_t stat,
    output logic           in_ready,
    output vgs_pkg::cmd_t  cmd
);
    import vgs_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A1     = 4'd2;
    localparam logic [3:0] S_A2     = 4'd3;
    localparam logic [3:0] S_MEM    = 4'd4;
    localparam logic [3:0] S_RDOUT  = 4'd5;
    localparam logic [3:0] S_WCHK   = 4'd6;
    localparam logic [3:0] S_WMASK  = 4'd7;
    localparam logic [3:0] S_WEMIT  = 4'd8;
    localparam logic [3:0] S_CLRACK = 4'd9;
    localparam logic [3:0] S_RINIT  = 4'd10;
    localparam logic [3:0] S_RMUL   = 4'd11;
    localparam logic [3:0] S_RSTEP  = 4'd12;
    localparam logic [3:0] S_RCHK   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            op_reg    <= OP_READ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd.op     = CMD_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = CMD_CLR;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op  = CMD_LOAD;
                    op_next = in_opcode;
                    unique case (in_opcode)
                        OP_READ, OP_WRITE: state_next = S_A1;
                        OP_RAY:            state_next = S_RINIT;
                        OP_CLEAR:          state_next = S_CLRACK;
                    endcase
                end
            end
            S_A1:
            begin
                cmd.op     = CMD_ADDR1;
                state_next = S_A2;
            end
            S_A2:
            begin
                cmd.op     = CMD_ADDR2;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                cmd.op = CMD_MEMRD;
                case (op_reg)
                    OP_READ:  state_next = S_RDOUT;
                    OP_WRITE: state_next = S_WCHK;
                    default:  state_next = S_RCHK;
                endcase
            end
            S_RDOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = CMD_EMIT_READ;
                    state_next = S_IDLE;
                end
            end
            S_WCHK:
            begin
                cmd.op     = CMD_WCHK;
                state_next = S_WMASK;
            end
            S_WMASK:
            begin
                cmd.op     = CMD_MASK;
                state_next = S_WEMIT;
            end
            S_WEMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = CMD_EMIT_DIRTY;
                    if (stat.emit_last)
                        state_next = S_IDLE;
                end
            end
            S_CLRACK:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = CMD_EMIT_CLEAR;
                    state_next = S_IDLE;
                end
            end
            S_RINIT:
            begin
                if (!stat.trivial)
                    state_next = S_RMUL;
                else if (stat.out_free)
                begin
                    cmd.op     = CMD_EMIT_NOHIT;
                    state_next = S_IDLE;
                end
            end
            S_RMUL:
            begin
                cmd.op = CMD_MUL;
                if (stat.k_last)
                    state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op     = CMD_STEP;
                state_next = S_A1;
            end
            S_RCHK:
            begin
                if (!(stat.ray_hit || stat.steps_done))
                    state_next = S_RSTEP;
                else if (stat.out_free)
                begin
                    cmd.op     = CMD_EMIT_RAY;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ready)
        else $error("request accepted during memory clearing pass");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_EMIT_READ || cmd.op == CMD_EMIT_DIRTY || cmd.op == CMD_EMIT_CLEAR ||
         cmd.op == CMD_EMIT_RAY || cmd.op == CMD_EMIT_NOHIT) |-> stat.out_free)
        else $error("result issued while output register is occupied");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("controller stayed idle after accepting a request");

endmodule

// ===== rtl/vgs_datapath.sv =====
module vgs_datapath #(
    parameter int CHUNK_EDGE = 8,
    parameter int CHUNKS_X   = 4,
    parameter int CHUNKS_Y   = 4,
    parameter int CHUNKS_Z   = 4,
    parameter int TYPE_BITS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  vgs_pkg::cmd_t  cmd,
    input  vgs_pkg::in_t   in_item,
    input  logic           out_ready,
    input  logic           cfg_valid,
    input  logic           cfg_index,
    input  logic [9:0]     cfg_data,
    output vgs_pkg::stat_t stat,
    output logic           out_valid,
    output vgs_pkg::res_t  res
);
    import vgs_pkg::*;

    localparam int WX = CHUNK_EDGE * CHUNKS_X;
    localparam int WY = CHUNK_EDGE * CHUNKS_Y;
    localparam int WZ = CHUNK_EDGE * CHUNKS_Z;
    localparam int CELL_COUNT  = WX * WY * WZ;
    localparam int CHUNK_COUNT = CHUNKS_X * CHUNKS_Y * CHUNKS_Z;
    localparam int CIDX_W = $clog2(CELL_COUNT);
    localparam int CIW    = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int CMP_W  = (TYPE_BITS > 8) ? TYPE_BITS : 8;
    localparam int RECIP  = 65536 / CHUNK_EDGE + 1;
    localparam int DZ     = CHUNKS_X * CHUNKS_Y;

    function automatic logic axis_in(input logic signed [MAP_W-1:0] c, input int w);
        axis_in = !c[MAP_W-1] && ($unsigned(c) < MAP_W'(w));
    endfunction

    function automatic logic dist_lt(input logic [DEN_W-1:0] da, input logic [DEN_W-1:0] db,
                                     input logic [P_W-1:0] pab, input logic [P_W-1:0] pba);
        dist_lt = (da != '0) && ((db == '0) || (pab < pba));
    endfunction

    logic [TYPE_BITS-1:0] mem [CELL_COUNT];

    logic [9:0]              max_steps_reg;
    logic [7:0]              air_reg;
    logic [CIDX_W-1:0]       clr_cnt_reg;
    logic [CHUNK_COUNT-1:0]  dirty_reg;
    logic                    ov_reg;
    logic [2:0]              k_reg;
    logic [STEP_W-1:0]       cnt_reg;

    logic                    use_ray_reg;
    logic signed [POS_W-1:0] pos_reg [3];
    logic [7:0]              nt_reg;
    logic [5:0]              sel_reg;
    logic signed [MAP_W-1:0] map_reg [3];
    logic [NUM_W-1:0]        num_reg [3];
    logic [DEN_W-1:0]        den_reg [3];
    logic                    neg_reg [3];
    logic [P_W-1:0]          p_reg [6];
    logic [2:0]              face_reg;
    logic                    inw_reg;
    logic [CIDX_W-1:0]       inner_reg;
    logic [CIDX_W-1:0]       addr_reg;
    logic [TYPE_BITS-1:0]    rdata_reg;
    logic [POS_W-1:0]        cq_reg [3];
    logic [CIW-1:0]          cinner_reg;
    logic                    on_face_reg;
    logic [CIW-1:0]          ci_reg;
    logic                    changed_reg;
    logic [6:0]              mask_reg;
    res_t                    res_reg;
    res_t                    res_next;

    logic signed [MAP_W-1:0] cur [3];
    logic signed [ORG_W-1:0] org [3];
    logic signed [DIR_W-1:0] dir [3];
    logic [TYPE_BITS-1:0]    nt_w;
    logic                    changed_now;
    logic                    we;
    logic [CIDX_W-1:0]       waddr;
    logic [TYPE_BITS-1:0]    wdata;
    logic                    ex [7];
    logic [CIW-1:0]          cif [7];
    logic [6:0]              newd;
    logic [2:0]              pick;
    logic [NUM_W-1:0]        mul_a;
    logic [DEN_W-1:0]        mul_b;
    logic [1:0]              ax;
    logic                    lt01, lt02, lt12;
    logic                    hit_now;
    logic [POS_W-1:0]        loc [3];
    logic                    on_face_now;

    assign org[0] = in_item.origin_x;
    assign org[1] = in_item.origin_y;
    assign org[2] = in_item.origin_z;
    assign dir[0] = in_item.dir_x;
    assign dir[1] = in_item.dir_y;
    assign dir[2] = in_item.dir_z;

    assign nt_w        = TYPE_BITS'(nt_reg);
    assign changed_now = inw_reg && (rdata_reg != nt_w);
    assign hit_now     = inw_reg && (CMP_W'(rdata_reg) != CMP_W'(air_reg));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (use_ray_reg)
                cur[a] = map_reg[a];
            else
                cur[a] = {{(MAP_W-POS_W){pos_reg[a][POS_W-1]}}, pos_reg[a]};
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = nt_w;
        if (cmd.op == CMD_CLR)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (cmd.op == CMD_WCHK && changed_now)
            we = 1'b1;
    end

    // cell lies on a chunk face when its offset inside the chunk is first or last
    always_comb
    begin
        on_face_now = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            loc[a] = POS_W'(pos_reg[a]) - cq_reg[a] * POS_W'(CHUNK_EDGE);
            if (loc[a] == '0 || loc[a] == POS_W'(CHUNK_EDGE - 1))
                on_face_now = 1'b1;
        end
    end

    // neighbour candidates in face order, own chunk first
    always_comb
    begin
        ex[0]  = 1'b1;
        cif[0] = ci_reg;
        ex[1]  = on_face_reg && ((11'(cq_reg[0]) + 11'd1) < 11'(CHUNKS_X));
        cif[1] = ci_reg + CIW'(1);
        ex[2]  = on_face_reg && (cq_reg[0] != '0);
        cif[2] = ci_reg - CIW'(1);
        ex[3]  = on_face_reg && ((11'(cq_reg[1]) + 11'd1) < 11'(CHUNKS_Y));
        cif[3] = ci_reg + CIW'(CHUNKS_X);
        ex[4]  = on_face_reg && (cq_reg[1] != '0);
        cif[4] = ci_reg - CIW'(CHUNKS_X);
        ex[5]  = on_face_reg && ((11'(cq_reg[2]) + 11'd1) < 11'(CHUNKS_Z));
        cif[5] = ci_reg + CIW'(DZ);
        ex[6]  = on_face_reg && (cq_reg[2] != '0);
        cif[6] = ci_reg - CIW'(DZ);
        for (int j = 0; j < 7; j++)
            newd[j] = ex[j] && !dirty_reg[cif[j]];
    end

    always_comb
    begin
        pick = 3'd0;
        for (int j = 6; j >= 0; j--)
        begin
            if (mask_reg[j])
                pick = 3'(j);
        end
    end

    always_comb
    begin
        case (k_reg)
            3'd0:    begin mul_a = num_reg[0]; mul_b = den_reg[1]; end
            3'd1:    begin mul_a = num_reg[1]; mul_b = den_reg[0]; end
            3'd2:    begin mul_a = num_reg[0]; mul_b = den_reg[2]; end
            3'd3:    begin mul_a = num_reg[2]; mul_b = den_reg[0]; end
            3'd4:    begin mul_a = num_reg[1]; mul_b = den_reg[2]; end
            default: begin mul_a = num_reg[2]; mul_b = den_reg[1]; end
        endcase
    end

    // tie order: x only when strictly nearest, then y only when strictly nearer than z, else z
    always_comb
    begin
        lt01 = dist_lt(den_reg[0], den_reg[1], p_reg[0], p_reg[1]);
        lt02 = dist_lt(den_reg[0], den_reg[2], p_reg[2], p_reg[3]);
        lt12 = dist_lt(den_reg[1], den_reg[2], p_reg[4], p_reg[5]);
        if (lt01 && lt02)
            ax = 2'd0;
        else if (lt12)
            ax = 2'd1;
        else
            ax = 2'd2;
    end

    always_comb
    begin
        res_next = res_reg;
        case (cmd.op)
            CMD_EMIT_READ:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_READ;
                res_next.type_out    = inw_reg ? 8'(rdata_reg) : air_reg;
                res_next.last        = 1'b1;
            end
            CMD_EMIT_DIRTY:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_WRITE;
                res_next.dirty_valid = (mask_reg != '0);
                res_next.dirty_chunk = (mask_reg != '0) ? 6'(cif[pick]) : 6'd0;
                res_next.last        = ((mask_reg & (mask_reg - 7'd1)) == '0);
            end
            CMD_EMIT_CLEAR:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_CLEAR;
                res_next.last        = 1'b1;
            end
            CMD_EMIT_RAY:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_RAY;
                res_next.last        = 1'b1;
                if (hit_now)
                begin
                    res_next.hit      = 1'b1;
                    res_next.hit_x    = map_reg[0];
                    res_next.hit_y    = map_reg[1];
                    res_next.hit_z    = map_reg[2];
                    res_next.hit_face = face_reg;
                end
            end
            CMD_EMIT_NOHIT:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_RAY;
                res_next.last        = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.op == CMD_MEMRD)
            rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= 10'(RESET_STEPS);
            air_reg       <= '0;
            clr_cnt_reg   <= '0;
            dirty_reg     <= '0;
            ov_reg        <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_STEPS: max_steps_reg <= cfg_data;
                    REG_AIR_CODE:  air_reg <= cfg_data[7:0];
                endcase
            end
            if (cmd.op == CMD_CLR)
                clr_cnt_reg <= clr_cnt_reg + CIDX_W'(1);
            if (cmd.op == CMD_LOAD)
            begin
                k_reg   <= '0;
                cnt_reg <= '0;
            end
            if (cmd.op == CMD_MUL)
                k_reg <= k_reg + 3'd1;
            if (cmd.op == CMD_STEP)
                cnt_reg <= cnt_reg + STEP_W'(1);
            if (cmd.op == CMD_EMIT_DIRTY && mask_reg != '0)
                dirty_reg[cif[pick]] <= 1'b1;
            if (cmd.op == CMD_EMIT_CLEAR && 32'(sel_reg) < 32'(CHUNK_COUNT))
                dirty_reg[CIW'(sel_reg)] <= 1'b0;
            if (cmd.op == CMD_EMIT_READ || cmd.op == CMD_EMIT_DIRTY ||
                cmd.op == CMD_EMIT_CLEAR || cmd.op == CMD_EMIT_RAY ||
                cmd.op == CMD_EMIT_NOHIT)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        case (cmd.op)
            CMD_LOAD:
            begin
                use_ray_reg <= (in_item.opcode == OP_RAY);
                pos_reg[0]  <= in_item.pos_x;
                pos_reg[1]  <= in_item.pos_y;
                pos_reg[2]  <= in_item.pos_z;
                nt_reg      <= in_item.new_type;
                sel_reg     <= in_item.chunk_sel;
                for (int a = 0; a < 3; a++)
                begin
                    map_reg[a] <= {{2{org[a][ORG_W-1]}}, org[a][ORG_W-1:8]};
                    den_reg[a] <= dir[a][DIR_W-1] ? DEN_W'(~dir[a] + 1'b1) : DEN_W'(dir[a]);
                    neg_reg[a] <= dir[a][DIR_W-1];
                    if (!dir[a][DIR_W-1] && dir[a] != '0)
                        num_reg[a] <= NUM_W'(9'd256 - {1'b0, org[a][7:0]});
                    else
                        num_reg[a] <= {1'b0, org[a][7:0]};
                end
            end
            CMD_ADDR1:
            begin
                inw_reg   <= axis_in(cur[0], WX) && axis_in(cur[1], WY) && axis_in(cur[2], WZ);
                inner_reg <= CIDX_W'(cur[1][POS_W-1:0])
                           + CIDX_W'(WY) * CIDX_W'(cur[2][POS_W-1:0]);
            end
            CMD_ADDR2:
            begin
                addr_reg <= CIDX_W'(cur[0][POS_W-1:0]) + CIDX_W'(WX) * inner_reg;
                for (int a = 0; a < 3; a++)
                    cq_reg[a] <= POS_W'((27'(pos_reg[a][POS_W-1:0]) * 27'(RECIP)) >> 16);
            end
            CMD_MEMRD:
            begin
                on_face_reg <= on_face_now;
                cinner_reg  <= CIW'(cq_reg[1]) + CIW'(CHUNKS_Y) * CIW'(cq_reg[2]);
            end
            CMD_WCHK:
            begin
                changed_reg <= changed_now;
                ci_reg      <= CIW'(cq_reg[0]) + CIW'(CHUNKS_X) * cinner_reg;
            end
            CMD_MASK:
                mask_reg <= changed_reg ? newd : 7'd0;
            CMD_MUL:
                p_reg[k_reg] <= P_W'(mul_a) * P_W'(mul_b);
            CMD_STEP:
            begin
                map_reg[ax] <= neg_reg[ax] ? map_reg[ax] - MAP_W'(1) : map_reg[ax] + MAP_W'(1);
                face_reg    <= {ax, !neg_reg[ax]};
                case (ax)
                    2'd0:
                    begin
                        p_reg[0] <= p_reg[0] + P_W'({den_reg[1], 8'd0});
                        p_reg[2] <= p_reg[2] + P_W'({den_reg[2], 8'd0});
                    end
                    2'd1:
                    begin
                        p_reg[1] <= p_reg[1] + P_W'({den_reg[0], 8'd0});
                        p_reg[4] <= p_reg[4] + P_W'({den_reg[2], 8'd0});
                    end
                    default:
                    begin
                        p_reg[3] <= p_reg[3] + P_W'({den_reg[0], 8'd0});
                        p_reg[5] <= p_reg[5] + P_W'({den_reg[1], 8'd0});
                    end
                endcase
            end
            CMD_EMIT_DIRTY:
                mask_reg <= mask_reg & (mask_reg - 7'd1);
            default: ;
        endcase
    end

    assign stat.clr_done   = (clr_cnt_reg == CIDX_W'(CELL_COUNT - 1));
    assign stat.out_free   = !ov_reg || out_ready;
    assign stat.k_last     = (k_reg == 3'd5);
    assign stat.trivial    = (den_reg[0] == '0 && den_reg[1] == '0 && den_reg[2] == '0) ||
                             (max_steps_reg == '0);
    assign stat.ray_hit    = hit_now;
    assign stat.steps_done = (cnt_reg == max_steps_reg);
    assign stat.emit_last  = ((mask_reg & (mask_reg - 7'd1)) == '0);

    assign out_valid = ov_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/voxel_grid_store_with_raycast_unit.sv =====
// Chunked voxel store with a cell-walking raycast.
// Requests enter on s_axis (tuser carries the opcode: read, write, raycast,
// clear dirty mark); results leave on m_axis with tuser as the result kind and
// tlast on the final result of each request. cfg_* writes max_steps (index 0)
// or air_code (index 1); cfg_ready is always high, write only while idle.
// One request is handled at a time by a state machine around one cell memory
// port. A read or write passes two address states and a registered memory
// read; a write then checks and masks, then issues its dirty-chunk results
// (up to seven results). A clear issues its result directly. A raycast forms
// its distance products, then each of N cells stepped (N <= max_steps) takes
// a step, two address states, a registered memory read and a check; a zero
// direction gives a no-hit result without stepping. The next request is
// accepted the cycle after the final result is loaded.
// After reset the cell memory is swept to zero one cell per cycle over
// CHUNK_EDGE^3*CHUNKS_X*CHUNKS_Y*CHUNKS_Z cells (32768 at default sizes);
// s_axis_tready stays low until the sweep ends. Dirty marks and registers
// reset at once. Results sit in an output register; while the receiver
// stalls the next request may still be accepted, and processing holds only
// when it must issue a result and the register is still occupied.
module voxel_grid_store_with_raycast_unit #(
    parameter int CHUNK_EDGE = 8,
    parameter int CHUNKS_X   = 4,
    parameter int CHUNKS_Y   = 4,
    parameter int CHUNKS_Z   = 4,
    parameter int TYPE_BITS  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, new_type, chunk_sel, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z
    input  logic [151:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // type_out, dirty_valid, dirty_chunk, hit, hit_x, hit_y, hit_z, hit_face
    output logic [55:0]  m_axis_tdata,
    // result_kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_data
);
    import vgs_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    in_t   in_item;
    res_t  res;

    assign in_item.opcode    = s_axis_tuser;
    assign in_item.pos_x     = s_axis_tdata[9:0];
    assign in_item.pos_y     = s_axis_tdata[19:10];
    assign in_item.pos_z     = s_axis_tdata[29:20];
    assign in_item.new_type  = s_axis_tdata[37:30];
    assign in_item.chunk_sel = s_axis_tdata[43:38];
    assign in_item.origin_x  = s_axis_tdata[61:44];
    assign in_item.origin_y  = s_axis_tdata[79:62];
    assign in_item.origin_z  = s_axis_tdata[97:80];
    assign in_item.dir_x     = s_axis_tdata[113:98];
    assign in_item.dir_y     = s_axis_tdata[129:114];
    assign in_item.dir_z     = s_axis_tdata[145:130];

    assign cfg_ready = 1'b1;

    vgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    vgs_datapath #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .CHUNKS_X   (CHUNKS_X),
        .CHUNKS_Y   (CHUNKS_Y),
        .CHUNKS_Z   (CHUNKS_Z),
        .TYPE_BITS  (TYPE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .out_ready (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .res       (res)
    );

    assign m_axis_tdata = {1'b0, res.hit_face, res.hit_z, res.hit_y, res.hit_x, res.hit,
                           res.dirty_chunk, res.dirty_valid, res.type_out};
    assign m_axis_tuser = res.result_kind;
    assign m_axis_tlast = res.last;

endmodule
